// File: hw/rtl/mcfd_pkg.sv
// ---------------------------------------------------------------------------
// mcfd_pkg: shared types and constants
// Frame layout, command codes, indicator codes and field widths for the
// motion command frame decoder.
// ---------------------------------------------------------------------------
package mcfd_pkg;

  localparam int FRAME_LEN  = 7;
  localparam int POS_W      = 3;
  localparam int ZERO_W     = 20;
  localparam int TARGET_W   = 21;
  localparam int SPEED_W    = 26;
  localparam int WORD_W     = 16;
  localparam int PROD_W     = 32;

  localparam logic [7:0] START_MARK = 8'hFF;
  localparam logic [7:0] BYTE_FULL  = 8'hFF;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] CMD_HOME   = 8'd0;
  localparam logic [7:0] CMD_SETPAR = 8'd3;
  localparam logic [7:0] CMD_STRETCH = 8'd4;
  localparam logic [7:0] CMD_RETURN = 8'd5;
  localparam logic [7:0] CMD_STOP   = 8'd7;

  localparam logic [1:0] LED_KEEP = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_OFF  = 2'd2;

  // floor(q / 25) = (q * RECIP25) >> RECIP_SHIFT, exact for q < 2**30
  localparam int          RECIP_W     = 31;
  localparam int          SCALED_W    = 61;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP25 = 31'd1374389535;

  typedef struct packed {
    logic              close;
    logic              start_ok;
    logic [7:0]        cmd;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
  } frame_t;

endpackage

// File: hw/rtl/mcfd_frame_asm.sv
// ---------------------------------------------------------------------------
// mcfd_frame_asm: byte framer
// Collects the first six bytes of a frame and presents the decoded frame
// when the escape byte (the seventh) is accepted.
// ---------------------------------------------------------------------------
module mcfd_frame_asm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_acc,
  input  logic [7:0]      rx_byte,
  output logic            last_next,
  output mcfd_pkg::frame_t frame
);

  logic [mcfd_pkg::POS_W-1:0] pos_r;
  logic [mcfd_pkg::POS_W-1:0] pos_nxt;
  logic [7:0]                 frame_r [0:mcfd_pkg::FRAME_LEN-2];
  logic [7:0]                 d0, d1, d2, d3;

  assign last_next = (pos_r == mcfd_pkg::POS_LAST);

  always_comb begin
    pos_nxt = pos_r;
    if (byte_acc) begin
      if (last_next) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc && !last_next) begin
      frame_r[pos_r] <= rx_byte;
    end
  end

  // escape bits 3..0 force data bytes 0..3 to all ones
  assign d0 = rx_byte[3] ? mcfd_pkg::BYTE_FULL : frame_r[2];
  assign d1 = rx_byte[2] ? mcfd_pkg::BYTE_FULL : frame_r[3];
  assign d2 = rx_byte[1] ? mcfd_pkg::BYTE_FULL : frame_r[4];
  assign d3 = rx_byte[0] ? mcfd_pkg::BYTE_FULL : frame_r[5];

  assign frame.close    = byte_acc && last_next;
  assign frame.start_ok = (frame_r[0] == mcfd_pkg::START_MARK);
  assign frame.cmd      = frame_r[1];
  assign frame.word0    = {d0, d1};
  assign frame.word1    = {d2, d3};

endmodule

// File: hw/rtl/mcfd_speed_calc.sv
// ---------------------------------------------------------------------------
// mcfd_speed_calc: average speed pipeline
// Computes floor(word0 * word1 / 100) over three register stages: product,
// reciprocal scaling by 1/25 of the product over four, then the result.
// ---------------------------------------------------------------------------
module mcfd_speed_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [mcfd_pkg::WORD_W-1:0]       word0,
  input  logic [mcfd_pkg::WORD_W-1:0]       word1,
  output logic [mcfd_pkg::SPEED_W-1:0]      speed
);

  logic [mcfd_pkg::PROD_W-1:0]   prod_r;
  logic [mcfd_pkg::PROD_W-1:0]   prod_nxt;
  logic [mcfd_pkg::SCALED_W-1:0] scaled_r;
  logic [mcfd_pkg::SCALED_W-1:0] scaled_nxt;
  logic [mcfd_pkg::SPEED_W-1:0]  speed_r;
  logic                          go1_r;
  logic                          go2_r;

  assign prod_nxt = {{(mcfd_pkg::PROD_W-mcfd_pkg::WORD_W){1'b0}}, word0}
                  * {{(mcfd_pkg::PROD_W-mcfd_pkg::WORD_W){1'b0}}, word1};

  // divide by 4 first, then by 25 through the reciprocal
  assign scaled_nxt =
    {{(mcfd_pkg::SCALED_W-mcfd_pkg::PROD_W+2){1'b0}}, prod_r[mcfd_pkg::PROD_W-1:2]}
    * {{(mcfd_pkg::SCALED_W-mcfd_pkg::RECIP_W){1'b0}}, mcfd_pkg::RECIP25};

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    scaled_r <= scaled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go1_r   <= 1'b0;
      go2_r   <= 1'b0;
      speed_r <= '0;
    end else begin
      go1_r <= go;
      go2_r <= go1_r;
      if (go2_r) begin
        speed_r <= scaled_r[mcfd_pkg::RECIP_SHIFT+mcfd_pkg::SPEED_W-1:mcfd_pkg::RECIP_SHIFT];
      end
    end
  end

  assign speed = speed_r;

endmodule

// File: hw/rtl/motion_command_frame_decoder.sv
// ---------------------------------------------------------------------------
// motion_command_frame_decoder: motion command frame decoder
// Groups received bytes into seven-byte frames, executes the command and
// issues one result request per frame with a good start byte.
// ---------------------------------------------------------------------------
// A result is in the output register in the cycle after the escape byte
// is accepted. Throughput: one byte per cycle; in_stall rises only for
// an escape byte while the previous result still waits on out_stall.
// The stored speed settles via the prod_r, scaled_r and speed_r registers.
// Reset clears the frame position, parameters, zero position and out_valid.
module motion_command_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_queue_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_command,
  output logic [1:0]  out_led_action,
  output logic        out_flush_queue,
  output logic        out_send_trajectory,
  output logic [20:0] out_start_position,
  output logic [20:0] out_end_position,
  output logic [25:0] out_average_speed
);

  mcfd_pkg::frame_t                 frame;
  logic                             last_next;
  logic                             byte_acc;
  logic                             load;
  logic                             setpar;
  logic [mcfd_pkg::SPEED_W-1:0]     speed;

  logic [mcfd_pkg::ZERO_W-1:0]      zero_pos_r;
  logic [mcfd_pkg::TARGET_W-1:0]    target_r;
  logic [mcfd_pkg::TARGET_W-1:0]    target_nxt;
  logic [mcfd_pkg::TARGET_W-1:0]    zero_ext;
  logic                             params_valid_r;

  logic                             out_valid_r;
  logic [7:0]                       command_r;
  logic [1:0]                       led_r, led_nxt;
  logic                             flush_r, flush_nxt;
  logic                             send_r, send_nxt;
  logic [mcfd_pkg::TARGET_W-1:0]    start_r, start_nxt;
  logic [mcfd_pkg::TARGET_W-1:0]    end_r, end_nxt;
  logic [mcfd_pkg::SPEED_W-1:0]     speed_r, speed_nxt;

  // hold only a closing byte while the result register is still full
  assign in_stall = out_valid_r && out_stall && last_next;
  assign byte_acc = in_valid && !in_stall;

  mcfd_frame_asm u_frame_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .last_next (last_next),
    .frame     (frame)
  );

  assign load   = frame.close && frame.start_ok;
  assign setpar = load && (frame.cmd == mcfd_pkg::CMD_SETPAR);

  mcfd_speed_calc u_speed_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (setpar),
    .word0 (frame.word0),
    .word1 (frame.word1),
    .speed (speed)
  );

  assign zero_ext   = {1'b0, zero_pos_r};
  assign target_nxt = zero_ext
                    + {{(mcfd_pkg::TARGET_W-mcfd_pkg::WORD_W){1'b0}}, frame.word0};

  always_comb begin
    led_nxt   = mcfd_pkg::LED_KEEP;
    flush_nxt = 1'b0;
    send_nxt  = 1'b0;
    start_nxt = '0;
    end_nxt   = '0;
    speed_nxt = '0;
    case (frame.cmd)
      mcfd_pkg::CMD_HOME: begin
        led_nxt = mcfd_pkg::LED_ON;
      end
      mcfd_pkg::CMD_STRETCH: begin
        if (params_valid_r && !in_queue_busy) begin
          send_nxt  = 1'b1;
          start_nxt = zero_ext;
          end_nxt   = target_r;
          speed_nxt = speed;
        end
      end
      mcfd_pkg::CMD_RETURN: begin
        if (params_valid_r && !in_queue_busy) begin
          send_nxt  = 1'b1;
          start_nxt = target_r;
          end_nxt   = zero_ext;
          speed_nxt = speed;
        end
      end
      mcfd_pkg::CMD_STOP: begin
        led_nxt   = mcfd_pkg::LED_OFF;
        flush_nxt = 1'b1;
      end
      default: begin
        led_nxt = mcfd_pkg::LED_KEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_pos_r     <= '0;
      target_r       <= '0;
      params_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        zero_pos_r <= cfg_wdata;
      end
      if (setpar) begin
        target_r       <= target_nxt;
        params_valid_r <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command_r <= frame.cmd;
      led_r     <= led_nxt;
      flush_r   <= flush_nxt;
      send_r    <= send_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      speed_r   <= speed_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command         = command_r;
  assign out_led_action      = led_r;
  assign out_flush_queue     = flush_r;
  assign out_send_trajectory = send_r;
  assign out_start_position  = start_r;
  assign out_end_position    = end_r;
  assign out_average_speed   = speed_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: motion command frame decoder regression
// Streams seven-byte command frames into the decoder under random valid and
// stall gaps, predicts every result from a behavioral copy of the decoder
// and compares each field. The run steps through several zero positions,
// long output back-pressure and runs with no idle cycles at all.
// ---------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [7:0]  rx_byte;
    logic        queue_busy;
    int unsigned gap;
  } serial_byte_t;

  typedef struct {
    logic [7:0]                    command;
    logic [1:0]                    led_action;
    logic                          flush_queue;
    logic                          send_trajectory;
    logic [mcfd_pkg::TARGET_W-1:0] start_position;
    logic [mcfd_pkg::TARGET_W-1:0] end_position;
    logic [mcfd_pkg::SPEED_W-1:0]  average_speed;
  } motion_action_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [mcfd_pkg::ZERO_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_rx_byte = '0;
  logic                          in_queue_busy = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_command;
  logic [1:0]                    out_led_action;
  logic                          out_flush_queue;
  logic                          out_send_trajectory;
  logic [mcfd_pkg::TARGET_W-1:0] out_start_position;
  logic [mcfd_pkg::TARGET_W-1:0] out_end_position;
  logic [mcfd_pkg::SPEED_W-1:0]  out_average_speed;

  motion_command_frame_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_queue_busy      (in_queue_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_led_action     (out_led_action),
    .out_flush_queue    (out_flush_queue),
    .out_send_trajectory(out_send_trajectory),
    .out_start_position (out_start_position),
    .out_end_position   (out_end_position),
    .out_average_speed  (out_average_speed)
  );

  always #6 clk = ~clk;

  // decoder copy
  int                            frame_pos = 0;
  logic [7:0]                    frame_buf [mcfd_pkg::FRAME_LEN-1];
  logic [mcfd_pkg::ZERO_W-1:0]   zero_pos = '0;
  logic [mcfd_pkg::TARGET_W-1:0] stretch_target = '0;
  logic [mcfd_pkg::SPEED_W-1:0]  stretch_speed = '0;
  logic                          params_valid = 1'b0;

  motion_action_t pending_actions [$];
  serial_byte_t   byte_stream [$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned dropped_frames = 0;
  int unsigned results_seen = 0;
  int unsigned trajectories = 0;
  int unsigned setpar_seen = 0;
  int unsigned led_seen = 0;
  int unsigned other_seen = 0;

  int unsigned tx_max_gap = 17;
  int unsigned rx_max_stall = 17;
  int unsigned holdoff_len = 0;
  int unsigned holdoff_seq = 0;

  bit in_took = 1'b0;
  bit out_took = 1'b0;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic track_frame_byte(input logic [7:0] rx, input logic busy);
    motion_action_t              act;
    logic [7:0]                  dat [4];
    logic [mcfd_pkg::WORD_W-1:0] w0;
    logic [mcfd_pkg::WORD_W-1:0] w1;
    logic [63:0]                 prod;
    if (frame_pos < mcfd_pkg::FRAME_LEN - 1) begin
      frame_buf[frame_pos] = rx;
      frame_pos++;
      return;
    end
    frame_pos = 0;
    if (frame_buf[0] != mcfd_pkg::START_MARK) begin
      dropped_frames++;
      return;
    end
    // escape bit 3 restores data0, bit 0 restores data3
    for (int i = 0; i < 4; i++)
      dat[i] = rx[3-i] ? mcfd_pkg::BYTE_FULL : frame_buf[2+i];
    w0 = {dat[0], dat[1]};
    w1 = {dat[2], dat[3]};
    act = '{command: frame_buf[1], led_action: mcfd_pkg::LED_KEEP, flush_queue: 1'b0,
            send_trajectory: 1'b0, start_position: '0, end_position: '0,
            average_speed: '0};
    case (frame_buf[1])
      mcfd_pkg::CMD_HOME: begin
        act.led_action = mcfd_pkg::LED_ON;
      end
      mcfd_pkg::CMD_SETPAR: begin
        prod = 64'(w0) * 64'(w1);
        stretch_target = mcfd_pkg::TARGET_W'(zero_pos) + mcfd_pkg::TARGET_W'(w0);
        stretch_speed = mcfd_pkg::SPEED_W'(prod / 100);
        params_valid = 1'b1;
      end
      mcfd_pkg::CMD_STRETCH, mcfd_pkg::CMD_RETURN: begin
        if (params_valid && !busy) begin
          act.send_trajectory = 1'b1;
          act.average_speed = stretch_speed;
          if (frame_buf[1] == mcfd_pkg::CMD_STRETCH) begin
            act.start_position = mcfd_pkg::TARGET_W'(zero_pos);
            act.end_position = stretch_target;
          end else begin
            act.start_position = stretch_target;
            act.end_position = mcfd_pkg::TARGET_W'(zero_pos);
          end
        end
      end
      mcfd_pkg::CMD_STOP: begin
        act.led_action = mcfd_pkg::LED_OFF;
        act.flush_queue = 1'b1;
      end
      default: ;
    endcase
    pending_actions.push_back(act);
  endtask

  // byte sender
  serial_byte_t next_item;
  bit           have_next = 1'b0;
  int unsigned  gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled request
    end else begin
      if (!have_next && byte_stream.size() != 0) begin
        next_item = byte_stream.pop_front();
        gap_left = next_item.gap;
        have_next = 1'b1;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (have_next) begin
        in_valid <= 1'b1;
        in_rx_byte <= next_item.rx_byte;
        in_queue_busy <= next_item.queue_busy;
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  int unsigned holdoff_seen = 0;

  always @(negedge clk) begin
    if (out_took) stall_left = $urandom_range(0, rx_max_stall);
    if (holdoff_seq != holdoff_seen) begin
      holdoff_seen = holdoff_seq;
      holdoff_left = holdoff_len;
    end
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (stall_left != 0 && out_valid) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    motion_action_t want;
    in_took = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) begin
      track_frame_byte(in_rx_byte, in_queue_busy);
      bytes_accepted++;
    end
    if (out_took) begin
      results_seen++;
      if (pending_actions.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, command 0x%0h", out_command));
      end else begin
        want = pending_actions.pop_front();
        check_field("command", 32'(out_command), 32'(want.command));
        check_field("led_action", 32'(out_led_action), 32'(want.led_action));
        check_field("flush_queue", 32'(out_flush_queue), 32'(want.flush_queue));
        check_field("send_trajectory", 32'(out_send_trajectory),
                    32'(want.send_trajectory));
        check_field("start_position", 32'(out_start_position),
                    32'(want.start_position));
        check_field("end_position", 32'(out_end_position), 32'(want.end_position));
        check_field("average_speed", 32'(out_average_speed),
                    32'(want.average_speed));
        if (want.send_trajectory) trajectories++;
        if (want.command == mcfd_pkg::CMD_SETPAR) setpar_seen++;
        else if (want.led_action != mcfd_pkg::LED_KEEP) led_seen++;
        else if (want.command != mcfd_pkg::CMD_STRETCH &&
                 want.command != mcfd_pkg::CMD_RETURN)
          other_seen++;
      end
    end
    if (rst_n && cfg_we) zero_pos = cfg_wdata;
  end

  task automatic queue_frame(input logic [7:0] start_b, input logic [7:0] cmd,
                             input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [7:0] d3,
                             input logic [7:0] esc, input logic busy);
    logic [7:0]   bytes [mcfd_pkg::FRAME_LEN];
    serial_byte_t item;
    bytes = '{start_b, cmd, d0, d1, d2, d3, esc};
    for (int i = 0; i < mcfd_pkg::FRAME_LEN; i++) begin
      item.rx_byte = bytes[i];
      // busy only counts on the escape byte; toggle it elsewhere as noise
      item.queue_busy = (i == mcfd_pkg::FRAME_LEN - 1) ? busy
                                                       : 1'($urandom_range(0, 1));
      item.gap = $urandom_range(0, tx_max_gap);
      byte_stream.push_back(item);
      bytes_queued++;
    end
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return mcfd_pkg::BYTE_FULL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_random_frame();
    logic [7:0] start_b;
    logic [7:0] cmd;
    logic [7:0] esc;
    start_b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254))
                                          : mcfd_pkg::START_MARK;
    case ($urandom_range(0, 15))
      0, 1:       cmd = mcfd_pkg::CMD_HOME;
      2, 3, 4:    cmd = mcfd_pkg::CMD_SETPAR;
      5, 6, 7:    cmd = mcfd_pkg::CMD_STRETCH;
      8, 9, 10:   cmd = mcfd_pkg::CMD_RETURN;
      11:         cmd = mcfd_pkg::CMD_STOP;
      12:         cmd = 8'd1;
      13:         cmd = 8'd2;
      14:         cmd = 8'd6;
      default:    cmd = 8'($urandom_range(8, 255));
    endcase
    esc = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) esc[3:0] = 4'h0;
    queue_frame(start_b, cmd, pick_data(), pick_data(), pick_data(), pick_data(),
                esc, $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || pending_actions.size() != 0)
      @(posedge clk);
    // let a dropped frame or a set-parameters update settle
    repeat (8) @(posedge clk);
  endtask

  task automatic write_zero_position(input logic [mcfd_pkg::ZERO_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [mcfd_pkg::ZERO_W-1:0] zero_setting;
    int                          waited;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames with the reset zero position
    queue_frame(mcfd_pkg::START_MARK, mcfd_pkg::CMD_STRETCH, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 1'b0);
    queue_frame(mcfd_pkg::START_MARK, mcfd_pkg::CMD_SETPAR, 8'h00, 8'h00, 8'h00, 8'h00,
                8'hFF, 1'b1);
    queue_frame(mcfd_pkg::START_MARK, mcfd_pkg::CMD_RETURN, 8'h0C, 8'h22, 8'h38, 8'h4E,
                8'h05, 1'b0);
    queue_frame(mcfd_pkg::START_MARK, mcfd_pkg::CMD_STRETCH, 8'hFF, 8'h00, 8'h01, 8'hFE,
                8'hF0, 1'b1);
    queue_frame(8'h00, mcfd_pkg::CMD_STOP, 8'h12, 8'h34, 8'h56, 8'h78, 8'h0F, 1'b0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0:       zero_setting = '1;
        1:       zero_setting = '0;
        4:       zero_setting = 20'd1;
        default: zero_setting = mcfd_pkg::ZERO_W'($urandom_range(0, 1048575));
      endcase
      write_zero_position(zero_setting);
      case (p)
        1:       begin tx_max_gap = 0;  rx_max_stall = 0;  end
        2:       begin tx_max_gap = 0;  rx_max_stall = 17; end
        3:       begin tx_max_gap = 17; rx_max_stall = 0;  end
        4:       begin tx_max_gap = 0;  rx_max_stall = 17; end
        default: begin tx_max_gap = 17; rx_max_stall = 17; end
      endcase
      if (p == 2) begin
        // hold the output long enough to back the decoder up into its input
        @(posedge clk);
        holdoff_len = 300;
        holdoff_seq++;
      end
      for (int f = 0; f < 43; f++) queue_random_frame();
    end

    waited = 0;
    while ((bytes_accepted != bytes_queued || pending_actions.size() != 0) &&
           waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (bytes_accepted != bytes_queued)
      flag_mismatch($sformatf("only %0d of %0d bytes accepted",
                              bytes_accepted, bytes_queued));
    if (pending_actions.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived",
                              pending_actions.size()));

    $display("Covered %0d bytes, %0d results, %0d dropped frames",
             bytes_accepted, results_seen, dropped_frames);
    $display("  %0d trajectories, %0d set-parameters, %0d led, %0d other commands",
             trajectories, setpar_seen, led_seen, other_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d of %0d bytes accepted, %0d results pending",
             bytes_accepted, bytes_queued, pending_actions.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
